/* rtl/etl_pkg.sv */
package etl_pkg;

    // Length limit and the widths that follow from it
    localparam int MAX_EXPR_LEN = 4096;
    localparam int POS_W        = $clog2(MAX_EXPR_LEN + 1);
    localparam int TS_W         = $clog2(MAX_EXPR_LEN);

    // Result field widths and saturation limits
    localparam int START_W   = 12;
    localparam int LEN_W     = 13;
    localparam int START_MAX = 4095;
    localparam int LEN_MAX   = 8191;

    // Up to three results per input byte
    localparam int RES_SLOTS   = 3;
    localparam int CNT_W       = $clog2(RES_SLOTS + 1);
    localparam int NUM_CAND    = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Character codes
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [3:0] {
        KIND_INT    = 4'd0,
        KIND_NAME   = 4'd1,
        KIND_ARROW  = 4'd2,
        KIND_DOT    = 4'd3,
        KIND_STAR   = 4'd4,
        KIND_AMP    = 4'd5,
        KIND_LSQ    = 4'd6,
        KIND_RSQ    = 4'd7,
        KIND_LPAR   = 4'd8,
        KIND_RPAR   = 4'd9,
        KIND_MINUS  = 4'd10,
        KIND_ERROR  = 4'd11,
        KIND_END    = 4'd12
    } etl_kind_t;

    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_INT    = 2'd1,
        PEND_NAME   = 2'd2,
        PEND_HYPHEN = 2'd3
    } etl_pend_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_INVALID  = 2'd1,
        ERR_TOO_LONG = 2'd2
    } etl_err_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       final_byte;
    } etl_byte_t;

    typedef struct packed {
        etl_kind_t          kind;
        logic [START_W-1:0] start_res;
        logic [LEN_W-1:0]   length;
        etl_err_t           error_code;
        logic [7:0]         bad_char;
    } etl_result_t;

    typedef struct packed {
        etl_result_t [RES_SLOTS-1:0] slot;
        logic [CNT_W-1:0]            count;
    } etl_bundle_t;

    // Character classes
    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_name_first(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
    endfunction

    function automatic logic is_name_more(input logic [7:0] c);
        return is_name_first(c) || is_digit(c);
    endfunction

    function automatic logic is_int_more(input logic [7:0] c);
        return is_digit(c) || (c == CH_X) || (c inside {[8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_LF, CH_CR, CH_SPACE};
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {CH_DOT, CH_STAR, CH_AMP, CH_LSQ, CH_RSQ, CH_LPAR, CH_RPAR};
    endfunction

    function automatic etl_kind_t punct_kind(input logic [7:0] c);
        etl_kind_t k;
        case (c)
            CH_DOT:  k = KIND_DOT;
            CH_STAR: k = KIND_STAR;
            CH_AMP:  k = KIND_AMP;
            CH_LSQ:  k = KIND_LSQ;
            CH_RSQ:  k = KIND_RSQ;
            CH_LPAR: k = KIND_LPAR;
            CH_RPAR: k = KIND_RPAR;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // Saturating conversions of an offset to the result fields
    function automatic logic [START_W-1:0] sat_start(input logic [POS_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'(START_MAX)) ? START_W'(START_MAX) : w[START_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : w[LEN_W-1:0];
    endfunction

    function automatic etl_result_t mk_result(input etl_kind_t k, input logic [START_W-1:0] s,
                                              input logic [LEN_W-1:0] l, input etl_err_t e,
                                              input logic [7:0] b);
        etl_result_t r;
        r.kind       = k;
        r.start_res  = s;
        r.length     = l;
        r.error_code = e;
        r.bad_char   = b;
        return r;
    endfunction

endpackage

/* rtl/expression_token_lexer_core.sv */
// Channel  Dir  tdata (low bit up)                                  tlast
// s_       in   ch[7:0]                                             final_byte
// m_       out  kind[3:0] start_res[15:4] length[28:16]             run_last
//               error_code[30:29] bad_char[38:31], zero fill [39]
//
// One input byte per cycle unless stalled; it produces zero to three results, shown
// one per cycle while m_tready is high. Path: byte register, lexer step, result
// register; a byte's results are loaded when the result register is free and can
// transfer from there. A byte with two or three results holds the input while the
// result register drains.
// Reset: aresetn low at a clock edge clears the lexer state and both stages.
// Stalls: m_tready low holds the result register; one more byte is still taken if the byte register is empty.
module expression_token_lexer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [etl_pkg::IN_TDATA_W-1:0]    s_tdata,   // ch[7:0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [etl_pkg::OUT_TDATA_W-1:0]   m_tdata,   // kind, start_res, length,
                                                         // error_code, bad_char
    output logic                              m_tlast
);

    etl_pkg::etl_byte_t   in_byte;
    etl_pkg::etl_bundle_t bundle;
    logic                 advance;
    logic                 out_free;

    etl_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .out_free (out_free),
        .advance  (advance),
        .in_byte  (in_byte)
    );

    etl_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (in_byte),
        .advance (advance),
        .bundle  (bundle)
    );

    etl_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .bundle   (bundle),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/etl_in_stage.sv */
module etl_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        s_tlast,
    input  logic                        out_free,
    output logic                        advance,
    output etl_pkg::etl_byte_t          in_byte
);

    logic               valid_reg;
    logic               valid_next;
    etl_pkg::etl_byte_t byte_reg;
    logic               take;

    // Byte moves on whenever the result stage can take a bundle
    assign advance  = valid_reg && out_free;
    assign s_tready = !valid_reg || out_free;
    assign take     = s_tvalid && s_tready;
    assign in_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            byte_reg.ch         <= s_tdata;
            byte_reg.final_byte <= s_tlast;
        end
    end

endmodule

/* rtl/etl_step.sv */
module etl_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  etl_pkg::etl_byte_t   in_byte,
    input  logic                 advance,
    output etl_pkg::etl_bundle_t bundle
);

    logic [etl_pkg::POS_W-1:0] position_reg;
    logic [etl_pkg::POS_W-1:0] position_next;
    etl_pkg::etl_pend_t        pend_reg;
    etl_pkg::etl_pend_t        pend_next;
    logic [etl_pkg::TS_W-1:0]  ts_reg;
    logic [etl_pkg::TS_W-1:0]  ts_next;
    logic                      es_reg;
    logic                      es_next;

    logic [7:0]                c;
    logic                      fin;
    logic [etl_pkg::POS_W-1:0] p;
    logic [etl_pkg::POS_W-1:0] p_plus1;
    logic [etl_pkg::POS_W-1:0] ts_ext;
    logic [etl_pkg::POS_W-1:0] new_ts_ext;
    logic                      too_long;
    logic                      live;
    logic                      cont;
    logic                      arrow;
    logic                      classify_on;
    logic                      cls_bad;
    logic                      cls_opens;
    logic                      es_step;
    etl_pkg::etl_pend_t        new_pend;
    logic [etl_pkg::TS_W-1:0]  new_ts;

    etl_pkg::etl_result_t      cand [etl_pkg::NUM_CAND];
    logic [etl_pkg::NUM_CAND-1:0] cvalid;
    logic [etl_pkg::CNT_W-1:0] cnt;

    assign c       = in_byte.ch;
    assign fin     = in_byte.final_byte;
    assign p       = position_reg;
    assign p_plus1 = p + etl_pkg::POS_W'(1);
    assign ts_ext  = etl_pkg::POS_W'(ts_reg);

    // Shared decode of the current byte against the open token
    assign too_long    = !es_reg && (p >= etl_pkg::POS_W'(etl_pkg::MAX_EXPR_LEN));
    assign live        = !es_reg && !too_long;
    assign cont        = ((pend_reg == etl_pkg::PEND_INT) && etl_pkg::is_int_more(c)) ||
                         ((pend_reg == etl_pkg::PEND_NAME) && etl_pkg::is_name_more(c));
    assign arrow       = (pend_reg == etl_pkg::PEND_HYPHEN) && (c == etl_pkg::CH_GT);
    assign classify_on = live && !cont && !arrow;
    assign cls_opens   = etl_pkg::is_digit(c) || etl_pkg::is_name_first(c) ||
                         (c == etl_pkg::CH_MINUS);
    assign cls_bad     = !etl_pkg::is_space(c) && !cls_opens && !etl_pkg::is_punct(c);
    assign es_step     = es_reg || too_long || (classify_on && cls_bad);

    // Open token after this byte, before any final flush
    always_comb begin
        new_pend = etl_pkg::PEND_NONE;
        new_ts   = ts_reg;
        if (live && cont) begin
            new_pend = pend_reg;
        end else if (classify_on) begin
            if (etl_pkg::is_digit(c)) begin
                new_pend = etl_pkg::PEND_INT;
            end else if (etl_pkg::is_name_first(c)) begin
                new_pend = etl_pkg::PEND_NAME;
            end else if (c == etl_pkg::CH_MINUS) begin
                new_pend = etl_pkg::PEND_HYPHEN;
            end
            if (cls_opens) begin
                new_ts = p[etl_pkg::TS_W-1:0];
            end
        end
    end

    assign new_ts_ext = etl_pkg::POS_W'(new_ts);

    // Candidate results in emission order: flush/limit error, classify, final flush, end
    always_comb begin
        cvalid = '0;

        if (too_long) begin
            cand[0] = etl_pkg::mk_result(etl_pkg::KIND_ERROR, etl_pkg::sat_start(p), '0,
                                         etl_pkg::ERR_TOO_LONG, 8'h00);
        end else if (arrow) begin
            cand[0] = etl_pkg::mk_result(etl_pkg::KIND_ARROW, etl_pkg::sat_start(ts_ext),
                                         etl_pkg::LEN_W'(2), etl_pkg::ERR_NONE, 8'h00);
        end else if (pend_reg == etl_pkg::PEND_HYPHEN) begin
            cand[0] = etl_pkg::mk_result(etl_pkg::KIND_MINUS, etl_pkg::sat_start(ts_ext),
                                         etl_pkg::LEN_W'(1), etl_pkg::ERR_NONE, 8'h00);
        end else begin
            cand[0] = etl_pkg::mk_result((pend_reg == etl_pkg::PEND_INT) ?
                                         etl_pkg::KIND_INT : etl_pkg::KIND_NAME,
                                         etl_pkg::sat_start(ts_ext),
                                         etl_pkg::sat_len(p - ts_ext),
                                         etl_pkg::ERR_NONE, 8'h00);
        end
        cvalid[0] = too_long || (live && (pend_reg != etl_pkg::PEND_NONE) && !cont);

        if (cls_bad) begin
            cand[1] = etl_pkg::mk_result(etl_pkg::KIND_ERROR, etl_pkg::sat_start(p), '0,
                                         etl_pkg::ERR_INVALID, c);
        end else begin
            cand[1] = etl_pkg::mk_result(etl_pkg::punct_kind(c), etl_pkg::sat_start(p),
                                         etl_pkg::LEN_W'(1), etl_pkg::ERR_NONE, 8'h00);
        end
        cvalid[1] = classify_on && (cls_bad || etl_pkg::is_punct(c));

        if (new_pend == etl_pkg::PEND_HYPHEN) begin
            cand[2] = etl_pkg::mk_result(etl_pkg::KIND_MINUS, etl_pkg::sat_start(new_ts_ext),
                                         etl_pkg::LEN_W'(1), etl_pkg::ERR_NONE, 8'h00);
        end else begin
            cand[2] = etl_pkg::mk_result((new_pend == etl_pkg::PEND_INT) ?
                                         etl_pkg::KIND_INT : etl_pkg::KIND_NAME,
                                         etl_pkg::sat_start(new_ts_ext),
                                         etl_pkg::sat_len(p_plus1 - new_ts_ext),
                                         etl_pkg::ERR_NONE, 8'h00);
        end
        cvalid[2] = fin && live && !es_step && (new_pend != etl_pkg::PEND_NONE);

        cand[3]   = etl_pkg::mk_result(etl_pkg::KIND_END, '0, '0, etl_pkg::ERR_NONE, 8'h00);
        cvalid[3] = fin;
    end

    // Pack the valid candidates into consecutive slots
    always_comb begin
        bundle = '0;
        cnt    = '0;
        for (int i = 0; i < etl_pkg::NUM_CAND; i++) begin
            if (cvalid[i]) begin
                bundle.slot[cnt] = cand[i];
                cnt              = cnt + etl_pkg::CNT_W'(1);
            end
        end
        bundle.count = cnt;
    end

    // Lexer state update; a final byte returns everything to reset
    always_comb begin
        position_next = position_reg;
        pend_next     = pend_reg;
        ts_next       = ts_reg;
        es_next       = es_reg;
        if (advance) begin
            if (fin) begin
                position_next = '0;
                pend_next     = etl_pkg::PEND_NONE;
                ts_next       = '0;
                es_next       = 1'b0;
            end else begin
                position_next = live ? p_plus1 : p;
                pend_next     = new_pend;
                ts_next       = new_ts;
                es_next       = es_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            pend_reg     <= etl_pkg::PEND_NONE;
            ts_reg       <= '0;
            es_reg       <= 1'b0;
        end else begin
            position_reg <= position_next;
            pend_reg     <= pend_next;
            ts_reg       <= ts_next;
            es_reg       <= es_next;
        end
    end

`ifndef SYNTHESIS
    // An error always closes the open token
    a_err_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        es_reg |-> (pend_reg == etl_pkg::PEND_NONE))
        else $error("token still open after error");

    // Offset stops at the limit
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= etl_pkg::POS_W'(etl_pkg::MAX_EXPR_LEN))
        else $error("position beyond limit");
`endif

endmodule

/* rtl/etl_out.sv */
module etl_out (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  etl_pkg::etl_bundle_t              bundle,
    output logic                              free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [etl_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);

    etl_pkg::etl_result_t [etl_pkg::RES_SLOTS-1:0] slot_reg;
    logic [etl_pkg::CNT_W-1:0] cnt_reg;
    logic [etl_pkg::CNT_W-1:0] cnt_next;
    logic [etl_pkg::CNT_W-1:0] idx_reg;
    logic [etl_pkg::CNT_W-1:0] idx_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      xfer;
    logic                      last;
    etl_pkg::etl_result_t      cur;

    // Serialize the bundle, one result per transfer
    assign last     = (idx_reg == (cnt_reg - etl_pkg::CNT_W'(1)));
    assign xfer     = valid_reg && m_tready;
    assign free     = !valid_reg || (xfer && last);
    assign cur      = slot_reg[idx_reg];
    assign m_tvalid = valid_reg;
    assign m_tlast  = last;
    assign m_tdata  = {1'b0, cur.bad_char, cur.error_code, cur.length, cur.start_res, cur.kind};

    always_comb begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = (bundle.count != '0);
            cnt_next   = bundle.count;
            idx_next   = '0;
        end else if (xfer) begin
            if (last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + etl_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= bundle.slot;
        end
    end

`ifndef SYNTHESIS
    // A shown result always lies inside the loaded bundle
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ((cnt_reg != '0) && (idx_reg < cnt_reg)))
        else $error("result index outside bundle");

    // A transfer that is not the last of its byte moves on to the next slot
    a_next_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer && !last) |=> (valid_reg && (idx_reg == $past(idx_reg) + etl_pkg::CNT_W'(1))))
        else $error("bundle drain skipped or lost a result");
`endif

endmodule

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected token as it should appear on the result channel
    typedef struct {
        etl_pkg::etl_kind_t kind;
        logic [11:0]        start_res;
        logic [12:0]        length;
        etl_pkg::etl_err_t  error_code;
        logic [7:0]         bad_char;
        logic               run_last;
    } lexed_tok_t;

    // One input byte; typed rows also carry their single hand-written result
    typedef struct {
        logic [7:0]         ch;
        logic               fin;
        bit                 typed;
        etl_pkg::etl_kind_t kind;
        int                 start;
        int                 len;
        etl_pkg::etl_err_t  err;
        logic [7:0]         bad;
    } stim_row_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [etl_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;   // ch[7:0]
    logic                            s_tlast  = 1'b0; // final_byte
    logic                            m_tvalid;
    logic                            m_tready = 1'b1;
    logic [etl_pkg::OUT_TDATA_W-1:0] m_tdata;         // kind, start_res, length,
                                                      // error_code, bad_char, zero fill
    logic                            m_tlast;         // run_last

    lexed_tok_t tok_q [$];
    stim_row_t  cur_row;
    int         items_sent    = 0;
    int         mismatches    = 0;
    int         quiet_left    = 0;
    bit         stall_request = 1'b0;

    // Lexer state mirror
    logic [12:0]        lx_pos    = '0;
    etl_pkg::etl_pend_t lx_pend   = etl_pkg::PEND_NONE;
    logic [11:0]        lx_tstart = '0;
    logic               lx_err    = 1'b0;

    logic [7:0] punct_set [7] = '{etl_pkg::CH_DOT, etl_pkg::CH_STAR, etl_pkg::CH_AMP,
                                  etl_pkg::CH_LSQ, etl_pkg::CH_RSQ, etl_pkg::CH_LPAR,
                                  etl_pkg::CH_RPAR};
    logic [7:0] blank_set [3] = '{etl_pkg::CH_LF, etl_pkg::CH_CR, etl_pkg::CH_SPACE};

    // Directed bytes: every token kind, blanks, errors and end-of-text cases
    stim_row_t dir_tab [26] = '{
        '{8'h28, 1'b0, 1'b1, etl_pkg::KIND_LPAR,  0, 1, etl_pkg::ERR_NONE,    8'h00},
        '{8'h29, 1'b0, 1'b1, etl_pkg::KIND_RPAR,  1, 1, etl_pkg::ERR_NONE,    8'h00},
        '{8'h2E, 1'b0, 1'b1, etl_pkg::KIND_DOT,   2, 1, etl_pkg::ERR_NONE,    8'h00},
        '{8'h2A, 1'b0, 1'b1, etl_pkg::KIND_STAR,  3, 1, etl_pkg::ERR_NONE,    8'h00},
        '{8'h26, 1'b0, 1'b1, etl_pkg::KIND_AMP,   4, 1, etl_pkg::ERR_NONE,    8'h00},
        '{8'h5B, 1'b0, 1'b1, etl_pkg::KIND_LSQ,   5, 1, etl_pkg::ERR_NONE,    8'h00},
        '{8'h5D, 1'b0, 1'b1, etl_pkg::KIND_RSQ,   6, 1, etl_pkg::ERR_NONE,    8'h00},
        // hyphen then '>' makes an arrow
        '{8'h2D, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h3E, 1'b0, 1'b1, etl_pkg::KIND_ARROW, 7, 2, etl_pkg::ERR_NONE,    8'h00},
        // hyphen closed by a digit is a minus; hex integer closed by a space
        '{8'h2D, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h31, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h78, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h46, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h20, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        // underscore name with a digit, closed by LF, then CR
        '{8'h5F, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h7A, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h39, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h0A, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h0D, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        // invalid byte, an ignored byte, then end on a zero byte
        '{8'hFF, 1'b0, 1'b1, etl_pkg::KIND_ERROR, 19, 0, etl_pkg::ERR_INVALID, 8'hFF},
        '{8'h61, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h00, 1'b1, 1'b1, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        // name closed by a high byte; after the error only the end comes out
        '{8'h71, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h80, 1'b0, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        '{8'h2D, 1'b1, 1'b1, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00},
        // lone hyphen as the final byte
        '{8'h2D, 1'b1, 1'b0, etl_pkg::KIND_END,   0, 0, etl_pkg::ERR_NONE,    8'h00}
    };

    expression_token_lexer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Character classes
    function automatic bit is_dec(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit opens_name(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               c == etl_pkg::CH_UNDER;
    endfunction

    function automatic bit extends_name(logic [7:0] c);
        return opens_name(c) || is_dec(c);
    endfunction

    function automatic bit extends_number(logic [7:0] c);
        return is_dec(c) || c == etl_pkg::CH_X || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic void push_tok(etl_pkg::etl_kind_t k, int unsigned s, int unsigned l,
                                     etl_pkg::etl_err_t e, logic [7:0] b);
        lexed_tok_t t;
        t.kind       = k;
        t.start_res  = (s > etl_pkg::START_MAX) ? 12'(etl_pkg::START_MAX) : 12'(s);
        t.length     = (l > etl_pkg::LEN_MAX) ? 13'(etl_pkg::LEN_MAX) : 13'(l);
        t.error_code = e;
        t.bad_char   = b;
        t.run_last   = 1'b0;
        tok_q.insert(tok_q.size(), t);
    endfunction

    // Emit the open token, which ends just before end_pos
    function automatic void close_token(int unsigned end_pos);
        case (lx_pend)
            etl_pkg::PEND_INT:    push_tok(etl_pkg::KIND_INT, lx_tstart, end_pos - lx_tstart,
                                           etl_pkg::ERR_NONE, 8'h00);
            etl_pkg::PEND_NAME:   push_tok(etl_pkg::KIND_NAME, lx_tstart, end_pos - lx_tstart,
                                           etl_pkg::ERR_NONE, 8'h00);
            etl_pkg::PEND_HYPHEN: push_tok(etl_pkg::KIND_MINUS, lx_tstart, 1,
                                           etl_pkg::ERR_NONE, 8'h00);
            default: ;
        endcase
        lx_pend = etl_pkg::PEND_NONE;
    endfunction

    // Fresh classification of a byte that no open token absorbed
    function automatic void open_or_emit(logic [7:0] c, int unsigned p);
        etl_pkg::etl_kind_t k;
        if (c == etl_pkg::CH_LF || c == etl_pkg::CH_CR || c == etl_pkg::CH_SPACE)
            return;
        if (is_dec(c) || opens_name(c) || c == etl_pkg::CH_MINUS) begin
            lx_pend   = is_dec(c) ? etl_pkg::PEND_INT :
                        (opens_name(c) ? etl_pkg::PEND_NAME : etl_pkg::PEND_HYPHEN);
            lx_tstart = 12'(p);
            return;
        end
        case (c)
            etl_pkg::CH_DOT:  k = etl_pkg::KIND_DOT;
            etl_pkg::CH_STAR: k = etl_pkg::KIND_STAR;
            etl_pkg::CH_AMP:  k = etl_pkg::KIND_AMP;
            etl_pkg::CH_LSQ:  k = etl_pkg::KIND_LSQ;
            etl_pkg::CH_RSQ:  k = etl_pkg::KIND_RSQ;
            etl_pkg::CH_LPAR: k = etl_pkg::KIND_LPAR;
            etl_pkg::CH_RPAR: k = etl_pkg::KIND_RPAR;
            default: begin
                lx_err = 1'b1;
                push_tok(etl_pkg::KIND_ERROR, p, 0, etl_pkg::ERR_INVALID, c);
                return;
            end
        endcase
        push_tok(k, p, 1, etl_pkg::ERR_NONE, 8'h00);
    endfunction

    // One lexer step: queue every token this byte produces
    function automatic void lex_step(logic [7:0] c, logic fin);
        int unsigned p;
        int          n0;
        bit          took;
        p    = lx_pos;
        n0   = tok_q.size();
        took = 1'b0;
        if (!lx_err) begin
            if (p >= etl_pkg::MAX_EXPR_LEN) begin
                lx_pend = etl_pkg::PEND_NONE;
                lx_err  = 1'b1;
                push_tok(etl_pkg::KIND_ERROR, p, 0, etl_pkg::ERR_TOO_LONG, 8'h00);
            end else begin
                case (lx_pend)
                    etl_pkg::PEND_INT:  if (extends_number(c)) took = 1'b1;
                                        else close_token(p);
                    etl_pkg::PEND_NAME: if (extends_name(c)) took = 1'b1;
                                        else close_token(p);
                    etl_pkg::PEND_HYPHEN: begin
                        if (c == etl_pkg::CH_GT) begin
                            push_tok(etl_pkg::KIND_ARROW, lx_tstart, 2, etl_pkg::ERR_NONE,
                                     8'h00);
                            lx_pend = etl_pkg::PEND_NONE;
                            took    = 1'b1;
                        end else begin
                            close_token(p);
                        end
                    end
                    default: ;
                endcase
                if (!took)
                    open_or_emit(c, p);
                lx_pos = 13'(p + 1);
                if (fin && !lx_err)
                    close_token(p + 1);
            end
        end
        if (fin) begin
            push_tok(etl_pkg::KIND_END, 0, 0, etl_pkg::ERR_NONE, 8'h00);
            lx_pos    = '0;
            lx_pend   = etl_pkg::PEND_NONE;
            lx_tstart = '0;
            lx_err    = 1'b0;
        end
        // Mark the final token of this byte
        if (tok_q.size() > n0)
            tok_q[tok_q.size() - 1].run_last = 1'b1;
    endfunction

    task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Result checking, then prediction for a byte taken at this edge
    always @(posedge aclk) begin : monitor
        lexed_tok_t want;
        lexed_tok_t hand;
        int         n0;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (tok_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got tdata=%h tlast=%b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = tok_q.pop_front();
                check_field("kind", 16'(want.kind), 16'(m_tdata[3:0]));
                check_field("start_res", 16'(want.start_res), 16'(m_tdata[15:4]));
                check_field("length", 16'(want.length), 16'(m_tdata[28:16]));
                check_field("error_code", 16'(want.error_code), 16'(m_tdata[30:29]));
                check_field("bad_char", 16'(want.bad_char), 16'(m_tdata[38:31]));
                check_field("run_last", 16'(want.run_last), 16'(m_tlast));
            end
        end
        if (aresetn && s_tvalid && s_tready === 1'b1) begin
            n0 = tok_q.size();
            lex_step(s_tdata, s_tlast);
            // hand-written rows replace the predicted token by their own
            if (cur_row.typed) begin
                while (tok_q.size() > n0)
                    void'(tok_q.pop_back());
                hand.kind       = cur_row.kind;
                hand.start_res  = 12'(cur_row.start);
                hand.length     = 13'(cur_row.len);
                hand.error_code = cur_row.err;
                hand.bad_char   = cur_row.bad;
                hand.run_last   = 1'b1;
                tok_q.insert(tok_q.size(), hand);
            end
        end
    end

    // Offer one byte, with a random gap in front; returns at the next falling edge
    task automatic send_byte(input stim_row_t row);
        int gap;
        int r;
        gap = 0;
        if (quiet_left > 0) begin
            quiet_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3)
                quiet_left = $urandom_range(20, 50);
            else if (r < 35)
                gap = $urandom_range(1, 3);
            else if (r < 42)
                gap = $urandom_range(4, 20);
        end
        if (gap > 0) begin
            s_tvalid = 1'b0;
            s_tdata  = etl_pkg::IN_TDATA_W'($urandom);
            s_tlast  = 1'($urandom);
            repeat (gap) @(negedge aclk);
        end
        cur_row  = row;
        s_tdata  = row.ch;
        s_tlast  = row.fin;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        @(negedge aclk);
        items_sent++;
    endtask

    function automatic logic [7:0] ident_char(bit head);
        int r;
        r = $urandom_range(0, head ? 52 : 62);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        if (r == 52) return etl_pkg::CH_UNDER;
        return 8'h30 + 8'(r - 53);
    endfunction

    task automatic send_text(input logic [7:0] txt [$]);
        stim_row_t row;
        row.typed = 1'b0;
        foreach (txt[i]) begin
            row.ch  = txt[i];
            row.fin = (i == txt.size() - 1);
            send_byte(row);
        end
    endtask

    // Mostly well-formed tokens with random content, a little noise
    task automatic send_random_expr();
        logic [7:0] txt [$];
        int         r;
        int         d;
        repeat ($urandom_range(1, 8)) begin
            r = $urandom_range(0, 99);
            if (r < 22) begin
                txt.insert(txt.size(), ident_char(1'b1));
                repeat ($urandom_range(0, 5)) txt.insert(txt.size(), ident_char(1'b0));
            end else if (r < 40) begin
                txt.insert(txt.size(), 8'h30 + 8'($urandom_range(0, 9)));
                repeat ($urandom_range(0, 5)) begin
                    d = $urandom_range(0, 22);
                    if (d < 10) txt.insert(txt.size(), 8'h30 + 8'(d));
                    else if (d < 16) txt.insert(txt.size(), 8'h61 + 8'(d - 10));
                    else if (d < 22) txt.insert(txt.size(), 8'h41 + 8'(d - 16));
                    else txt.insert(txt.size(), etl_pkg::CH_X);
                end
            end else if (r < 58) begin
                txt.insert(txt.size(), punct_set[$urandom_range(0, 6)]);
            end else if (r < 66) begin
                txt.insert(txt.size(), etl_pkg::CH_MINUS);
                txt.insert(txt.size(), etl_pkg::CH_GT);
            end else if (r < 72) begin
                txt.insert(txt.size(), etl_pkg::CH_MINUS);
            end else if (r < 85) begin
                repeat ($urandom_range(1, 2))
                    txt.insert(txt.size(), blank_set[$urandom_range(0, 2)]);
            end else if (r < 93) begin
                txt.insert(txt.size(), 8'($urandom_range(8'h21, 8'h7E)));
            end else begin
                txt.insert(txt.size(), 8'($urandom_range(0, 255)));
            end
        end
        send_text(txt);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (tok_q.size() != 0) @(negedge aclk);
    endtask

    // Sink side: random back-pressure, free-running stretches, one long hold
    initial begin : receiver
        int hold;
        int steady;
        int r;
        hold   = 0;
        steady = 0;
        forever begin
            @(negedge aclk);
            if (stall_request) begin
                m_tready = 1'b0;
                repeat (80) @(negedge aclk);
                stall_request = 1'b0;
                m_tready      = 1'b1;
            end else if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else if (steady > 0) begin
                m_tready = 1'b1;
                steady--;
            end else begin
                m_tready = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 25)
                    hold = $urandom_range(1, 3);
                else if (r < 30)
                    hold = $urandom_range(6, 30);
                else if (r < 33)
                    steady = $urandom_range(20, 60);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int base;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[i]) send_byte(dir_tab[i]);
        wait_drained();

        base = items_sent;
        while (items_sent < base + 80) send_random_expr();
        // sink holds off while bytes keep coming
        stall_request = 1'b1;
        while (items_sent < base + 120) send_random_expr();
        wait_drained();

        base = items_sent;
        while (items_sent < base + 50) send_random_expr();
        wait_drained();
        repeat (20) @(negedge aclk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
